### src/sbpe_pkg.sv
// ----------------------------------------------------------------------------
// sbpe_pkg
// Types, codes and constants shared by the servo bus packet engine files.
// ----------------------------------------------------------------------------
package sbpe_pkg;

	typedef enum logic [2:0] {
		OP_READ      = 3'd0,
		OP_WRITE     = 3'd1,
		OP_REG_WRITE = 3'd2,
		OP_ACTION    = 3'd3,
		OP_RX_BYTE   = 3'd4,
		OP_TICK      = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		KIND_TX      = 3'd0,
		KIND_DATA    = 3'd1,
		KIND_NODATA  = 3'd2,
		KIND_FAIL    = 3'd3,
		KIND_REFUSED = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TX,
		ST_ONE,
		ST_EV_REQ,
		ST_EV_CHK,
		ST_DAT_REQ,
		ST_DAT_OUT
	} state_t;

	localparam int MEM_AW = 5;

	typedef struct packed {
		logic              wr_en;
		logic [MEM_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              clr;
		logic              rd_en;
		logic [MEM_AW-1:0] rd_addr;
	} mem_req_t;

	localparam int          TPB_W          = 10;
	localparam logic [9:0]  TPB_RESET      = 10'd40;
	localparam int          IDLE_W         = 14;
	localparam logic [13:0] IDLE_MAX       = 14'h3FFF;
	localparam int          RCV_W          = 5;
	localparam logic [4:0]  REPLY_OVERHEAD = 5'd6;
	localparam logic [4:0]  MAX_READ_BYTES = 5'd8;
	localparam logic [3:0]  MAX_WRITE_BYTES = 4'd2;

	localparam logic [7:0]  HDR_BYTE       = 8'hFF;
	localparam logic [7:0]  BCAST_ID       = 8'hFE;
	localparam logic [7:0]  INS_READ       = 8'h02;
	localparam logic [7:0]  INS_WRITE      = 8'h03;
	localparam logic [7:0]  INS_REG_WRITE  = 8'h04;
	localparam logic [7:0]  INS_ACTION     = 8'h05;
	localparam logic [7:0]  READ_LEN       = 8'h04;
	localparam logic [7:0]  WRITE_LEN_BASE = 8'h03;
	localparam logic [7:0]  ACTION_LEN     = 8'h02;

	localparam logic [MEM_AW-1:0] RPL_SUM_POS  = 5'd2;
	localparam logic [MEM_AW-1:0] RPL_LEN_POS  = 5'd3;
	localparam logic [MEM_AW-1:0] RPL_ERR_POS  = 5'd4;
	localparam logic [MEM_AW-1:0] RPL_DATA_POS = 5'd5;

endpackage

### src/sbpe_req_if.sv
// ----------------------------------------------------------------------------
// sbpe_req_if
// Request channel: command, received bus byte or tick, with valid/ready.
// ----------------------------------------------------------------------------
interface sbpe_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [7:0]  servo_id;
	logic [7:0]  reg_address;
	logic [3:0]  byte_count;
	logic [15:0] write_data;
	logic [7:0]  rx_byte;

	modport source (
		output valid, operation, servo_id, reg_address, byte_count, write_data, rx_byte,
		input  ready
	);
	modport sink (
		input  valid, operation, servo_id, reg_address, byte_count, write_data, rx_byte,
		output ready
	);
endinterface

### src/sbpe_rsp_if.sv
// ----------------------------------------------------------------------------
// sbpe_rsp_if
// Result channel: transmit bytes, read data and status, with valid/ready.
// ----------------------------------------------------------------------------
interface sbpe_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] byte_value;
	logic [7:0] status_error;
	logic       last;

	modport source (
		output valid, kind, byte_value, status_error, last,
		input  ready
	);
	modport sink (
		input  valid, kind, byte_value, status_error, last,
		output ready
	);
endinterface

### src/sbpe_reply_mem.sv
// ----------------------------------------------------------------------------
// sbpe_reply_mem
// Reply byte store: one write port, one registered read port, per-entry
// valid bits so that an unwritten entry reads as zero after a clear.
// ----------------------------------------------------------------------------
module sbpe_reply_mem #(
	parameter int REPLY_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sbpe_pkg::mem_req_t mem_req,
	output logic [7:0]        rdata
);
	localparam int AW = $clog2(REPLY_DEPTH);

	logic [7:0]             mem_q [REPLY_DEPTH];
	logic [REPLY_DEPTH-1:0] vld_q;
	logic [7:0]             rdata_q;
	logic [AW-1:0]          waddr;
	logic [AW-1:0]          raddr;

	assign waddr = mem_req.wr_addr[AW-1:0];
	assign raddr = mem_req.rd_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[waddr] <= mem_req.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_req.clr) begin
			vld_q <= '0;
		end else if (mem_req.wr_en) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			rdata_q <= vld_q[raddr] ? mem_q[raddr] : 8'h00;
		end
	end

	assign rdata = rdata_q;

endmodule

### src/sbpe_seq.sv
// ----------------------------------------------------------------------------
// sbpe_seq
// Packet sequencer: frames instruction packets, tracks the pending reply,
// sweeps the reply store to check it and drives the result register.
// ----------------------------------------------------------------------------
module sbpe_seq #(
	parameter int REPLY_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [9:0]         tpbt,
	sbpe_req_if.sink           req,
	sbpe_rsp_if.source         rsp,
	output sbpe_pkg::mem_req_t mem_req,
	input  logic [7:0]         mem_rdata
);
	sbpe_pkg::state_t state_q, state_d;

	logic                     awaiting_q;
	logic [3:0]               expected_q;
	logic [4:0]               rcv_q;
	logic [13:0]              idle_q;

	logic [7:0]               body_q [6];
	logic [7:0]               body_d [6];
	logic [2:0]               nbody_q, nbody_d;
	logic [3:0]               tx_idx_q;
	logic [7:0]               tx_sum_q;
	logic                     bcast_q, bcast_d;

	sbpe_pkg::kind_t          one_kind_q, one_kind_d;
	logic [7:0]               one_err_q, one_err_d;

	logic [sbpe_pkg::MEM_AW-1:0] ev_addr_q;
	logic [7:0]               len_q;
	logic [7:0]               sum_q;
	logic [7:0]               err_q;
	logic [3:0]               nd_q;
	logic [3:0]               di_q;

	logic                     out_valid_q;
	sbpe_pkg::kind_t          kind_q;
	logic [7:0]               value_q;
	logic [7:0]               serr_q;
	logic                     last_q;

	logic                     acc, out_free, busy_ref, rd_bad, wr_bad;
	logic [4:0]               cnt5, rcv_inc, need;
	logic                     rx_done, timeout;
	logic [13:0]              idle_inc;
	logic [14:0]              limit;

	logic                     one_ld, tx_ld, start_read, rx_wr, rx_eval, tick_upd, tick_fail;

	logic                     tx_is_hdr, tx_is_body, tx_is_ck, tx_last;
	logic [3:0]               tx_body_end;
	logic [2:0]               bidx;
	logic [7:0]               tx_byte;

	logic [7:0]               a8, len_e, sum_n, err_n, nd_raw;
	logic [8:0]               a9, len9;
	logic                     at_len, bad_len, in_sum, is_ck, ck_bad, ev_done;
	logic [3:0]               nd_n;
	logic                     dat_last;

	logic                     emit_v, emit_last;
	sbpe_pkg::kind_t          emit_kind;
	logic [7:0]               emit_val, emit_err;

	assign req.ready = (state_q == sbpe_pkg::ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign cnt5     = {1'b0, req.byte_count};
	assign rd_bad   = (req.byte_count == 4'd0) || (cnt5 > sbpe_pkg::MAX_READ_BYTES);
	assign wr_bad   = (req.byte_count == 4'd0) || (req.byte_count > sbpe_pkg::MAX_WRITE_BYTES);
	assign busy_ref = awaiting_q && (req.operation <= sbpe_pkg::OP_ACTION);

	assign rcv_inc  = rcv_q + 5'd1;
	assign need     = sbpe_pkg::REPLY_OVERHEAD + {1'b0, expected_q};
	assign rx_done  = (rcv_inc >= need);
	assign idle_inc = (idle_q < sbpe_pkg::IDLE_MAX) ? idle_q + 14'd1 : idle_q;
	assign limit    = 15'(need) * 15'(tpbt);
	assign timeout  = ({1'b0, idle_inc} >= limit);

	assign tx_body_end = {1'b0, nbody_q} + 4'd2;
	assign tx_is_hdr   = (tx_idx_q < 4'd2);
	assign tx_is_body  = !tx_is_hdr && (tx_idx_q < tx_body_end);
	assign tx_is_ck    = !tx_is_hdr && !tx_is_body;
	assign tx_last     = tx_is_ck && !bcast_q;
	assign bidx        = 3'(tx_idx_q - 4'd2);
	assign tx_byte     = tx_is_hdr ? sbpe_pkg::HDR_BYTE :
	                     tx_is_body ? body_q[bidx] : ~tx_sum_q;

	assign a8      = 8'(ev_addr_q);
	assign a9      = {1'b0, a8};
	assign at_len  = (ev_addr_q == sbpe_pkg::RPL_LEN_POS);
	assign len_e   = at_len ? mem_rdata : len_q;
	assign len9    = {1'b0, len_e};
	assign bad_len = at_len && (mem_rdata > 8'(REPLY_DEPTH - 6));
	assign in_sum  = (ev_addr_q == sbpe_pkg::RPL_SUM_POS) || (a9 <= len9 + 9'd2);
	assign sum_n   = in_sum ? sum_q + mem_rdata : sum_q;
	assign is_ck   = (ev_addr_q >= sbpe_pkg::RPL_LEN_POS) && (a9 == len9 + 9'd3);
	assign ck_bad  = is_ck && (~sum_q != mem_rdata);
	assign err_n   = (ev_addr_q == sbpe_pkg::RPL_ERR_POS) ? mem_rdata : err_q;
	assign ev_done = (ev_addr_q >= sbpe_pkg::RPL_ERR_POS) && (a9 >= len9 + 9'd3);
	assign nd_raw  = (len_e >= 8'd2) ? len_e - 8'd2 : 8'd0;
	assign nd_n    = (nd_raw > {4'b0, expected_q}) ? expected_q : nd_raw[3:0];

	assign dat_last = (di_q == nd_q - 4'd1);

	always_comb begin
		state_d    = state_q;
		one_ld     = 1'b0;
		one_kind_d = sbpe_pkg::KIND_REFUSED;
		one_err_d  = 8'h00;
		tx_ld      = 1'b0;
		body_d     = body_q;
		nbody_d    = nbody_q;
		bcast_d    = 1'b0;
		start_read = 1'b0;
		rx_wr      = 1'b0;
		rx_eval    = 1'b0;
		tick_upd   = 1'b0;
		tick_fail  = 1'b0;
		emit_v     = 1'b0;
		emit_kind  = sbpe_pkg::KIND_TX;
		emit_val   = 8'h00;
		emit_err   = 8'h00;
		emit_last  = 1'b0;
		mem_req    = '0;

		case (state_q)
			sbpe_pkg::ST_IDLE: begin
				if (acc) begin
					if (busy_ref) begin
						one_ld  = 1'b1;
						state_d = sbpe_pkg::ST_ONE;
					end else begin
						case (sbpe_pkg::op_t'(req.operation))
							sbpe_pkg::OP_READ: begin
								if (rd_bad) begin
									one_ld  = 1'b1;
									state_d = sbpe_pkg::ST_ONE;
								end else begin
									tx_ld     = 1'b1;
									body_d[0] = req.servo_id;
									body_d[1] = sbpe_pkg::READ_LEN;
									body_d[2] = sbpe_pkg::INS_READ;
									body_d[3] = req.reg_address;
									body_d[4] = {4'b0, req.byte_count};
									nbody_d   = 3'd5;
									state_d   = sbpe_pkg::ST_TX;
									if (req.servo_id == sbpe_pkg::BCAST_ID) begin
										bcast_d    = 1'b1;
										one_ld     = 1'b1;
										one_kind_d = sbpe_pkg::KIND_NODATA;
										one_err_d  = sbpe_pkg::BCAST_ID;
									end else begin
										start_read = 1'b1;
									end
								end
							end
							sbpe_pkg::OP_WRITE, sbpe_pkg::OP_REG_WRITE: begin
								if (wr_bad) begin
									one_ld  = 1'b1;
									state_d = sbpe_pkg::ST_ONE;
								end else begin
									tx_ld     = 1'b1;
									body_d[0] = req.servo_id;
									body_d[1] = sbpe_pkg::WRITE_LEN_BASE + {4'b0, req.byte_count};
									body_d[2] = (req.operation == sbpe_pkg::OP_REG_WRITE) ?
									            sbpe_pkg::INS_REG_WRITE : sbpe_pkg::INS_WRITE;
									body_d[3] = req.reg_address;
									body_d[4] = req.write_data[7:0];
									body_d[5] = req.write_data[15:8];
									nbody_d   = 3'd4 + req.byte_count[2:0];
									state_d   = sbpe_pkg::ST_TX;
								end
							end
							sbpe_pkg::OP_ACTION: begin
								tx_ld     = 1'b1;
								body_d[0] = sbpe_pkg::BCAST_ID;
								body_d[1] = sbpe_pkg::ACTION_LEN;
								body_d[2] = sbpe_pkg::INS_ACTION;
								nbody_d   = 3'd3;
								state_d   = sbpe_pkg::ST_TX;
							end
							sbpe_pkg::OP_RX_BYTE: begin
								if (awaiting_q) begin
									rx_wr = 1'b1;
									mem_req.wr_en   = ({1'b0, rcv_q} < 6'(REPLY_DEPTH));
									mem_req.wr_addr = rcv_q;
									mem_req.wr_data = req.rx_byte;
									if (rx_done) begin
										rx_eval = 1'b1;
										state_d = sbpe_pkg::ST_EV_REQ;
									end
								end
							end
							sbpe_pkg::OP_TICK: begin
								if (awaiting_q) begin
									tick_upd = 1'b1;
									if (timeout) begin
										tick_fail  = 1'b1;
										one_ld     = 1'b1;
										one_kind_d = sbpe_pkg::KIND_FAIL;
										state_d    = sbpe_pkg::ST_ONE;
									end
								end
							end
							default: begin
								state_d = sbpe_pkg::ST_IDLE;
							end
						endcase
					end
				end
				mem_req.clr = start_read;
			end
			sbpe_pkg::ST_TX: begin
				emit_v    = 1'b1;
				emit_kind = sbpe_pkg::KIND_TX;
				emit_val  = tx_byte;
				emit_last = tx_last;
				if (out_free && tx_is_ck) begin
					state_d = bcast_q ? sbpe_pkg::ST_ONE : sbpe_pkg::ST_IDLE;
				end
			end
			sbpe_pkg::ST_ONE: begin
				emit_v    = 1'b1;
				emit_kind = one_kind_q;
				emit_err  = one_err_q;
				emit_last = 1'b1;
				if (out_free) begin
					state_d = sbpe_pkg::ST_IDLE;
				end
			end
			sbpe_pkg::ST_EV_REQ: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = ev_addr_q;
				state_d         = sbpe_pkg::ST_EV_CHK;
			end
			sbpe_pkg::ST_EV_CHK: begin
				if (bad_len || ck_bad) begin
					one_ld     = 1'b1;
					one_kind_d = sbpe_pkg::KIND_FAIL;
					state_d    = sbpe_pkg::ST_ONE;
				end else if (ev_done) begin
					if (nd_n == 4'd0) begin
						one_ld     = 1'b1;
						one_kind_d = sbpe_pkg::KIND_NODATA;
						one_err_d  = err_n;
						state_d    = sbpe_pkg::ST_ONE;
					end else begin
						state_d = sbpe_pkg::ST_DAT_REQ;
					end
				end else begin
					state_d = sbpe_pkg::ST_EV_REQ;
				end
			end
			sbpe_pkg::ST_DAT_REQ: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = sbpe_pkg::RPL_DATA_POS + {1'b0, di_q};
				state_d         = sbpe_pkg::ST_DAT_OUT;
			end
			sbpe_pkg::ST_DAT_OUT: begin
				emit_v    = 1'b1;
				emit_kind = sbpe_pkg::KIND_DATA;
				emit_val  = mem_rdata;
				emit_err  = err_q;
				emit_last = dat_last;
				if (out_free) begin
					state_d = dat_last ? sbpe_pkg::ST_IDLE : sbpe_pkg::ST_DAT_REQ;
				end
			end
			default: begin
				state_d = sbpe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbpe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b0;
			expected_q  <= 4'd0;
			rcv_q       <= 5'd0;
			idle_q      <= 14'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_read) begin
				awaiting_q <= 1'b1;
				expected_q <= req.byte_count;
				rcv_q      <= 5'd0;
				idle_q     <= 14'd0;
			end
			if (rx_wr) begin
				rcv_q  <= rcv_inc;
				idle_q <= 14'd0;
			end
			if (tick_upd) begin
				idle_q <= idle_inc;
			end
			if (rx_eval || tick_fail) begin
				awaiting_q <= 1'b0;
			end
			if (emit_v && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tx_ld) begin
			body_q   <= body_d;
			nbody_q  <= nbody_d;
			bcast_q  <= bcast_d;
			tx_idx_q <= 4'd0;
			tx_sum_q <= 8'h00;
		end else if (state_q == sbpe_pkg::ST_TX && out_free) begin
			tx_idx_q <= tx_idx_q + 4'd1;
			if (tx_is_body) begin
				tx_sum_q <= tx_sum_q + tx_byte;
			end
		end
		if (one_ld) begin
			one_kind_q <= one_kind_d;
			one_err_q  <= one_err_d;
		end
		if (rx_eval) begin
			ev_addr_q <= sbpe_pkg::RPL_SUM_POS;
			sum_q     <= 8'h00;
		end else if (state_q == sbpe_pkg::ST_EV_CHK) begin
			ev_addr_q <= ev_addr_q + 1'b1;
			sum_q     <= sum_n;
			err_q     <= err_n;
			len_q     <= len_e;
			nd_q      <= nd_n;
			di_q      <= 4'd0;
		end else if (state_q == sbpe_pkg::ST_DAT_OUT && out_free) begin
			di_q <= di_q + 4'd1;
		end
		if (emit_v && out_free) begin
			kind_q  <= emit_kind;
			value_q <= emit_val;
			serr_q  <= emit_err;
			last_q  <= emit_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = kind_q;
	assign rsp.byte_value   = value_q;
	assign rsp.status_error = serr_q;
	assign rsp.last         = last_q;

`ifndef SYNTHESIS
	a_wr_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> awaiting_q)
		else $error("reply store written with no reply pending");

	a_clr_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.clr && mem_req.wr_en))
		else $error("reply store cleared and written together");

	a_rcv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_q |-> (rcv_q < need))
		else $error("reply byte count passed its expected length");

	a_ev_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbpe_pkg::ST_EV_REQ) |-> ({1'b0, ev_addr_q} < 6'(REPLY_DEPTH)))
		else $error("reply check address outside the store");

	a_dat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbpe_pkg::ST_DAT_OUT) |-> (nd_q != 4'd0))
		else $error("data phase entered with no data bytes");
`endif

endmodule

### src/servo_bus_packet_engine_top.sv
// A transmit request (read, write, registered write, action) is accepted and
// then each packet byte passes through the result register in turn, 6 to 9
// results. When the last reply byte arrives the checker sweeps the reply
// store through its single read port, reading and then checking each byte
// from the id through the checksum, then reading and emitting each data byte
// returned. The store has per-entry valid bits cleared whenever a non-broadcast
// read starts, so no clearing pass runs after reset. Requests are taken only
// while the sequencer is idle; the final result may still wait in the output
// register when the next request enters.
// ----------------------------------------------------------------------------
// servo_bus_packet_engine_top
// Servo bus packet engine: config register, packet sequencer and reply store.
// ----------------------------------------------------------------------------
module servo_bus_packet_engine_top #(
	parameter int REPLY_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [9:0] cfg_wr_data,
	sbpe_req_if.sink   req,
	sbpe_rsp_if.source rsp
);
	logic [sbpe_pkg::TPB_W-1:0] tpbt_q;
	sbpe_pkg::mem_req_t         mem_req;
	logic [7:0]                 mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpbt_q <= sbpe_pkg::TPB_RESET;
		end else if (cfg_wr_en) begin
			tpbt_q <= cfg_wr_data;
		end
	end

	sbpe_seq #(
		.REPLY_DEPTH (REPLY_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.tpbt      (tpbt_q),
		.req       (req),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	sbpe_reply_mem #(
		.REPLY_DEPTH (REPLY_DEPTH)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rdata   (mem_rdata)
	);

endmodule
